### hdl/rle_dc_pkg.sv
// Shared types, constants and helpers for the run-length encoder with decimal counts.
// Used by rle_dc_run, rle_dc_emit and rle_decimal_count_encoder; no dependencies.
package rle_dc_pkg;

  // run length counter width and saturation point
  localparam int LenW = 16;
  localparam logic [LenW-1:0] MaxRun = 16'hFFFF;

  // decimal digits needed for a length of LenW bits
  localparam int DigN = 5;
  localparam int BcdW = 4 * DigN;
  localparam int DigIdxW = 3;

  localparam logic [7:0] Terminator = 8'h2F;
  localparam logic [7:0] AsciiZero = 8'h30;

  // emitter phases, in the order the bytes go out
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_A_DIG,
    PH_A_BYTE,
    PH_B_DIG,
    PH_B_BYTE,
    PH_TERM
  } phase_t;

  // what one input item asks the emitter to send
  typedef struct packed {
    logic              flush_a;  // run ended by this item
    logic [7:0]        a_byte;
    logic [BcdW-1:0]   a_bcd;
    logic [DigIdxW-1:0] a_ndig;  // 0 when the run has length one
    logic              flush_b;  // run flushed at end of stream
    logic [7:0]        b_byte;
    logic [BcdW-1:0]   b_bcd;
    logic [DigIdxW-1:0] b_ndig;
    logic              term;     // terminator follows
  } desc_t;

  // increment a packed decimal count by one
  function automatic logic [BcdW-1:0] bcd_inc(input logic [BcdW-1:0] v);
    logic [BcdW-1:0] r;
    logic            carry;
    r = v;
    carry = 1'b1;
    for (int i = 0; i < DigN; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // number of significant decimal digits
  function automatic logic [DigIdxW-1:0] bcd_ndig(input logic [BcdW-1:0] v);
    logic [DigIdxW-1:0] n;
    n = '0;
    for (int i = 0; i < DigN; i++) begin
      if (v[4*i +: 4] != 4'd0) begin
        n = DigIdxW'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

### hdl/rle_decimal_count_encoder.sv
// A transfer that ends a run or the stream loads the emitter's phase and descriptor registers;
// each byte then leaves through the output register. An item that only opens or extends a run
// is taken when the emitter is free; one that ends a run holds it for all its bytes (up to 8).
// Reset (rst, synchronous): no run open, emitter idle, output empty.
// Top level of the run-length encoder with decimal counts; uses rle_dc_pkg,
// rle_dc_run and rle_dc_emit.
module rle_decimal_count_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte[7:0]
  input  logic       s_tlast,   // end_of_stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast    // last_of_burst
);
  import rle_dc_pkg::*;

  desc_t desc;
  logic  desc_valid;
  logic  accept;
  logic  free;

  // input transfer whenever the emitter can take a new burst
  assign s_tready = free;
  assign accept = s_tvalid && s_tready;

  rle_dc_run u_run (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_tdata),
    .end_of_stream (s_tlast),
    .desc          (desc),
    .desc_valid    (desc_valid)
  );

  rle_dc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && desc_valid),
    .desc_in  (desc),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### hdl/rle_dc_run.sv
// Run tracker: holds the open run (byte, binary and decimal length) and describes
// the bytes each accepted item must emit. Depends on rle_dc_pkg.
module rle_dc_run (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output rle_dc_pkg::desc_t desc,
  output logic              desc_valid
);
  import rle_dc_pkg::*;

  logic [7:0]      run_byte, run_byte_next;
  logic [LenW-1:0] run_len, run_len_next;
  logic [BcdW-1:0] run_bcd, run_bcd_next;
  logic            run_open, run_open_next;

  logic            same;
  logic [7:0]      new_byte;
  logic [LenW-1:0] new_len;
  logic [BcdW-1:0] new_bcd;

  // extend or close the run and build the burst description
  always_comb begin
    same = run_open && (data_byte == run_byte) && (run_len < MaxRun);
    new_byte = same ? run_byte : data_byte;
    new_len = same ? run_len + LenW'(1) : LenW'(1);
    new_bcd = same ? bcd_inc(run_bcd) : BcdW'(1);

    desc.flush_a = run_open && !same;
    desc.a_byte = run_byte;
    desc.a_bcd = run_bcd;
    desc.a_ndig = (run_len >= LenW'(2)) ? bcd_ndig(run_bcd) : '0;
    desc.flush_b = end_of_stream;
    desc.b_byte = new_byte;
    desc.b_bcd = new_bcd;
    desc.b_ndig = same ? bcd_ndig(new_bcd) : '0;
    desc.term = end_of_stream;
    desc_valid = desc.flush_a || end_of_stream;

    if (end_of_stream) begin
      run_byte_next = '0;
      run_len_next = '0;
      run_bcd_next = '0;
      run_open_next = 1'b0;
    end else begin
      run_byte_next = new_byte;
      run_len_next = new_len;
      run_bcd_next = new_bcd;
      run_open_next = 1'b1;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_byte <= '0;
      run_len <= '0;
      run_bcd <= '0;
      run_open <= 1'b0;
    end else if (accept) begin
      run_byte <= run_byte_next;
      run_len <= run_len_next;
      run_bcd <= run_bcd_next;
      run_open <= run_open_next;
    end
  end

endmodule

### hdl/rle_dc_emit.sv
// Byte emitter: walks a burst description one byte per cycle, while the output is not stalled,
// into the output register. Depends on rle_dc_pkg.
module rle_dc_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rle_dc_pkg::desc_t desc_in,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_byte[7:0]
  output logic              m_tlast    // last_of_burst
);
  import rle_dc_pkg::*;

  desc_t              desc;
  phase_t             phase, phase_next;
  logic [DigIdxW-1:0] dig, dig_next;

  logic               out_free;
  logic               emit_go;
  logic [7:0]         emit_byte;
  logic               emit_last;
  phase_t             after;
  logic               stay;

  // phase that follows ph for descriptor d
  function automatic phase_t phase_after(input phase_t ph, input desc_t d);
    phase_t r;
    if (ph < PH_A_DIG && d.flush_a && d.a_ndig != '0) begin
      r = PH_A_DIG;
    end else if (ph < PH_A_BYTE && d.flush_a) begin
      r = PH_A_BYTE;
    end else if (ph < PH_B_DIG && d.flush_b && d.b_ndig != '0) begin
      r = PH_B_DIG;
    end else if (ph < PH_B_BYTE && d.flush_b) begin
      r = PH_B_BYTE;
    end else if (ph < PH_TERM && d.term) begin
      r = PH_TERM;
    end else begin
      r = PH_IDLE;
    end
    return r;
  endfunction

  // first digit index for the phase entered
  function automatic logic [DigIdxW-1:0] dig_start(input phase_t ph, input desc_t d);
    logic [DigIdxW-1:0] r;
    r = '0;
    if (ph == PH_A_DIG) begin
      r = d.a_ndig - DigIdxW'(1);
    end else if (ph == PH_B_DIG) begin
      r = d.b_ndig - DigIdxW'(1);
    end
    return r;
  endfunction

  assign out_free = !m_tvalid || m_tready;

  // output byte for the current phase
  always_comb begin
    emit_go = (phase != PH_IDLE) && out_free;
    stay = ((phase == PH_A_DIG) || (phase == PH_B_DIG)) && (dig != '0);
    after = phase_after(phase, desc);
    emit_last = !stay && (after == PH_IDLE);
    case (phase)
      PH_A_DIG:  emit_byte = AsciiZero | {4'h0, desc.a_bcd[dig*4 +: 4]};
      PH_A_BYTE: emit_byte = desc.a_byte;
      PH_B_DIG:  emit_byte = AsciiZero | {4'h0, desc.b_bcd[dig*4 +: 4]};
      PH_B_BYTE: emit_byte = desc.b_byte;
      PH_TERM:   emit_byte = Terminator;
      default:   emit_byte = '0;
    endcase
    free = (phase == PH_IDLE) || (emit_go && emit_last);
  end

  // next phase and digit index
  always_comb begin
    phase_next = phase;
    dig_next = dig;
    if (emit_go) begin
      if (stay) begin
        dig_next = dig - DigIdxW'(1);
      end else begin
        phase_next = after;
        dig_next = dig_start(after, desc);
      end
    end
    if (load) begin
      phase_next = phase_after(PH_IDLE, desc_in);
      dig_next = dig_start(phase_next, desc_in);
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
    dig <= dig_next;
    if (load) begin
      desc <= desc_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit_go;
    end
    if (out_free) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_last;
    end
  end

endmodule
